// File: src/gafs_pkg.sv
// ----------------------------------------------------------------------------
// gafs_pkg
// Shared types, constants and fixed point helpers of the fitness scaler.
// ----------------------------------------------------------------------------
package gafs_pkg;

  localparam int FRAC_BITS = 16;
  localparam int WIDE      = 66;
  localparam int DIV_STEPS = 48;

  // mode codes
  localparam logic [2:0] MODE_NONE   = 3'd0;
  localparam logic [2:0] MODE_WINDOW = 3'd1;
  localparam logic [2:0] MODE_RANK   = 3'd2;
  localparam logic [2:0] MODE_LINEAR = 3'd3;
  localparam logic [2:0] MODE_SIGMA  = 3'd4;

  // register indexes
  localparam logic [2:0] REG_MODE  = 3'd0;
  localparam logic [2:0] REG_SCALE = 3'd1;
  localparam logic [2:0] REG_BEST  = 3'd2;
  localparam logic [2:0] REG_WORST = 3'd3;
  localparam logic [2:0] REG_AVG   = 3'd4;
  localparam logic [2:0] REG_DEV   = 3'd5;
  localparam logic [2:0] REG_POP   = 3'd6;

  localparam logic signed [WIDE-1:0] FRAC_MASK = (66'sd1 <<< FRAC_BITS) - 66'sd1;
  localparam logic [31:0] ONE_Q    = 32'd1 << FRAC_BITS;
  localparam logic [31:0] ONE_Q_P1 = (32'd1 << FRAC_BITS) + 32'd1;

  // coefficient sequencer states
  typedef enum logic [3:0] {
    CS_IDLE, CS_L0, CS_L1, CS_L2, CS_L3, CS_DV,
    CS_A0, CS_A1, CS_A2, CS_A3, CS_B0, CS_B1,
    CS_G0, CS_G1, CS_G2
  } cstate_t;

  // coefficients derived from configuration
  typedef struct packed {
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [47:0] so;
    logic               flag;
  } coef_t;

  // clip to 32-bit signed range, flag in the top bit
  function automatic logic [32:0] sat32(input logic signed [WIDE-1:0] v);
    logic [32:0] res;
    if (v > 66'sd2147483647) res = {1'b1, 32'h7fffffff};
    else if (v < -66'sd2147483648) res = {1'b1, 32'h80000000};
    else res = {1'b0, v[31:0]};
    return res;
  endfunction

  // divide by 2^FRAC_BITS, rounding toward zero
  function automatic logic signed [WIDE-1:0] trunc_frac(input logic signed [WIDE-1:0] v);
    logic signed [WIDE-1:0] adj;
    adj = v + (v[WIDE-1] ? FRAC_MASK : 66'sd0);
    return adj >>> FRAC_BITS;
  endfunction

endpackage

// File: src/gafs_div.sv
// ----------------------------------------------------------------------------
// gafs_div
// Restoring divider, one quotient bit per cycle, signed result.
// ----------------------------------------------------------------------------
module gafs_div import gafs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [47:0]        num_mag,
  input  logic [32:0]        den_mag,
  input  logic               neg,
  output logic               done,
  output logic signed [48:0] quo_s
);

  logic [32:0] rem;
  logic [47:0] quo;
  logic [32:0] den;
  logic [5:0]  cnt;
  logic        sign;
  logic        run;
  logic [33:0] rem_sh;
  logic        fits;

  assign rem_sh = {rem, quo[47]};
  assign fits   = rem_sh >= {1'b0, den};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= 6'(DIV_STEPS);
      end else if (run) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath; the remainder stays below the divisor
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quo  <= num_mag;
      den  <= den_mag;
      sign <= neg;
    end else if (run) begin
      rem <= fits ? 33'(rem_sh - {1'b0, den}) : rem_sh[32:0];
      quo <= {quo[46:0], fits};
    end
  end

  assign quo_s = sign ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

endmodule

// File: src/gafs_coef.sv
// ----------------------------------------------------------------------------
// gafs_coef
// Derives linear and sigma coefficients from configuration with one shared
// multiplier and an iterative divider; busy while it runs.
// ----------------------------------------------------------------------------
module gafs_coef import gafs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               restart,
  input  logic [30:0]        sf,
  input  logic signed [31:0] mx,
  input  logic signed [31:0] mn,
  input  logic signed [31:0] av,
  input  logic [30:0]        dev,
  output coef_t              coef,
  output logic               busy
);

  cstate_t state, state_next;

  logic signed [32:0]     opx, opy;
  logic signed [WIDE-1:0] prod, p1, tnum;
  logic signed [31:0]     aa;
  logic                   cond_a;

  logic [31:0]            f;
  logic signed [32:0]     f1;
  logic signed [WIDE-1:0] tnum_c;
  logic                   cond_c;
  logic signed [32:0]     d_c;
  logic [32:0]            dmag;
  logic                   div_start, div_done;
  logic signed [48:0]     quo_s;
  logic [32:0]            q_sat, t_sat, m_sat;

  // clamped factor
  assign f  = ({1'b0, sf} < ONE_Q_P1) ? ONE_Q_P1 : {1'b0, sf};
  assign f1 = $signed({1'b0, f}) - $signed({1'b0, ONE_Q});

  // compare and denominator, valid in CS_L3
  assign tnum_c = (66'(mx) <<< FRAC_BITS) - prod;
  assign cond_c = p1 > -tnum_c;
  assign d_c    = cond_c ? 33'(mx) - 33'(av) : 33'(av) - 33'(mn);
  assign dmag   = d_c[32] ? 33'(-d_c) : 33'(d_c);

  assign div_start = (state == CS_L3) && (d_c != 33'sd0);

  gafs_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .num_mag ({(av[31] ? 32'(-av) : 32'(av)), 16'h0}),
    .den_mag (dmag),
    .neg     (av[31] ^ d_c[32]),
    .done    (div_done),
    .quo_s   (quo_s)
  );

  assign q_sat = sat32(66'(quo_s));
  assign t_sat = sat32(trunc_frac(tnum));
  assign m_sat = (state == CS_B1) ? sat32(trunc_frac(-prod)) : sat32(trunc_frac(prod));

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= CS_L0;
    else if (restart) state <= CS_L0;
    else state <= state_next;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      CS_IDLE: state_next = CS_IDLE;
      CS_L0:   state_next = CS_L1;
      CS_L1:   state_next = CS_L2;
      CS_L2:   state_next = CS_L3;
      CS_L3:   state_next = (d_c == 33'sd0) ? CS_G0 : CS_DV;
      CS_DV:   if (div_done) state_next = cond_a ? CS_A0 : CS_B0;
      CS_A0:   state_next = CS_A1;
      CS_A1:   state_next = CS_A2;
      CS_A2:   state_next = CS_A3;
      CS_A3:   state_next = CS_G0;
      CS_B0:   state_next = CS_B1;
      CS_B1:   state_next = CS_G0;
      CS_G0:   state_next = CS_G1;
      CS_G1:   state_next = CS_G2;
      CS_G2:   state_next = CS_IDLE;
      default: state_next = CS_IDLE;
    endcase
  end

  assign busy = (state != CS_IDLE);

  // shared multiplier, registered
  always_ff @(posedge clk) begin
    prod <= 66'(opx * opy);
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      CS_L0: begin
        opx       <= 33'(mn);
        opy       <= f1;
        coef.flag <= 1'b0;
      end
      CS_L1: begin
        opx <= $signed({1'b0, f});
        opy <= 33'(av);
      end
      CS_L2: p1 <= prod;
      CS_L3: begin
        tnum   <= tnum_c;
        cond_a <= cond_c;
        if (d_c == 33'sd0) begin
          coef.a <= $signed(ONE_Q);
          coef.b <= 32'sd0;
        end
      end
      CS_DV: begin
        if (div_done) begin
          coef.flag <= coef.flag | q_sat[32];
          if (cond_a) aa <= q_sat[31:0];
          else begin
            coef.a <= q_sat[31:0];
            opx    <= 33'(mn);
            opy    <= 33'($signed(q_sat[31:0]));
          end
        end
      end
      CS_A0: begin
        coef.flag <= coef.flag | t_sat[32];
        opx       <= 33'(aa);
        opy       <= 33'($signed(t_sat[31:0]));
      end
      CS_A1: begin
        opx <= 33'(aa);
        opy <= f1;
      end
      CS_A2: begin
        coef.b    <= m_sat[31:0];
        coef.flag <= coef.flag | m_sat[32];
      end
      CS_A3: begin
        coef.a    <= m_sat[31:0];
        coef.flag <= coef.flag | m_sat[32];
      end
      CS_B1: begin
        coef.b    <= m_sat[31:0];
        coef.flag <= coef.flag | m_sat[32];
      end
      CS_G0: begin
        opx <= $signed({2'b0, sf});
        opy <= $signed({2'b0, dev});
      end
      CS_G2: coef.so <= 48'(av) - 48'(prod >>> FRAC_BITS);
      default: ;
    endcase
  end

endmodule

// File: src/gafs_pipe.sv
// ----------------------------------------------------------------------------
// gafs_pipe
// Four-stage per-request datapath: mode select, multiply, add, saturate.
// ----------------------------------------------------------------------------
module gafs_pipe import gafs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               acc,
  input  logic signed [31:0] r,
  input  logic [9:0]         rank,
  input  logic [2:0]         mode,
  input  logic signed [31:0] worst,
  input  logic [10:0]        pop,
  input  coef_t              coef,
  output logic               vld,
  output logic signed [31:0] scaled,
  output logic               sat
);

  logic                   v1, v2, v3;
  logic signed [31:0]     r1;
  logic signed [49:0]     x1, x2, x3;
  logic signed [63:0]     prod2;
  logic signed [47:0]     lin3;
  logic signed [49:0]     x0;
  logic signed [WIDE-1:0] sel;
  logic [32:0]            res;

  // stage 1: non-linear modes
  always_comb begin
    case (mode)
      MODE_WINDOW: x0 = 50'(r) - 50'(worst);
      MODE_RANK:   x0 = (50'($signed({1'b0, pop})) - 50'sd1
                         - 50'($signed({1'b0, rank}))) <<< FRAC_BITS;
      MODE_SIGMA:  x0 = 50'(r) - 50'(coef.so);
      default:     x0 = 50'(r);
    endcase
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1  <= 1'b0;
      v2  <= 1'b0;
      v3  <= 1'b0;
      vld <= 1'b0;
    end else if (en) begin
      v1  <= acc;
      v2  <= v1;
      v3  <= v2;
      vld <= v3;
    end
  end

  // data stages
  assign sel = (mode == MODE_LINEAR) ? 66'(lin3) : 66'(x3);
  assign res = sat32(sel);

  always_ff @(posedge clk) begin
    if (en) begin
      r1     <= r;
      x1     <= x0;
      prod2  <= 64'(r1 * coef.a);
      x2     <= x1;
      lin3   <= 48'(trunc_frac(66'(prod2))) + 48'(coef.b);
      x3     <= x2;
      scaled <= res[31:0];
      sat    <= res[32] | ((mode == MODE_LINEAR) & coef.flag);
    end
  end

endmodule

// File: src/ga_fitness_scaling.sv
// ----------------------------------------------------------------------------
// ga_fitness_scaling
// Genetic algorithm fitness scaler: window, ranking, linear and sigma modes, plus pass-through.
// ----------------------------------------------------------------------------
// Usage:
//   Requests carry raw_score and rank_index on in_valid/in_stall; results
//   leave on out_valid/out_stall with scaled_fitness and saturated. A request
//   is taken when valid is high and stall is low.
//   out_valid and the result come out of one register per stage of the
//   four-stage multiply-add datapath; throughput is one request per cycle
//   while in_stall is low.
//   Configuration is written through cfg_we/cfg_index/cfg_data while no
//   request is in flight. Every write, and reset, starts a coefficient pass
//   (shared multiplier plus 48-step divider), during which in_stall is high.
//   Reset loads default registers, empties the pipeline and runs the
//   coefficient pass. When out_stall holds a result, the whole pipeline
//   freezes and in_stall rises; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module ga_fitness_scaling import gafs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] raw_score,
  input  logic [9:0]         rank_index,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] scaled_fitness,
  output logic               saturated,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  logic [2:0]         mode;
  logic [30:0]        scale_factor;
  logic signed [31:0] best_fitness, worst_fitness, average_fitness;
  logic [30:0]        fitness_deviation;
  logic [10:0]        population_size;

  coef_t coef;
  logic  busy, en, acc;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode              <= MODE_NONE;
      scale_factor      <= 31'd131072;
      best_fitness      <= '0;
      worst_fitness     <= '0;
      average_fitness   <= '0;
      fitness_deviation <= '0;
      population_size   <= 11'd1024;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE:  mode              <= cfg_data[2:0];
        REG_SCALE: scale_factor      <= cfg_data[30:0];
        REG_BEST:  best_fitness      <= cfg_data;
        REG_WORST: worst_fitness     <= cfg_data;
        REG_AVG:   average_fitness   <= cfg_data;
        REG_DEV:   fitness_deviation <= cfg_data[30:0];
        REG_POP:   population_size   <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  gafs_coef u_coef (
    .clk     (clk),
    .rst     (rst),
    .restart (cfg_we),
    .sf      (scale_factor),
    .mx      (best_fitness),
    .mn      (worst_fitness),
    .av      (average_fitness),
    .dev     (fitness_deviation),
    .coef    (coef),
    .busy    (busy)
  );

  // pipeline advance and handshake
  assign en       = !(out_valid && out_stall);
  assign in_stall = busy || !en;
  assign acc      = in_valid && !in_stall;

  gafs_pipe u_pipe (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .acc    (acc),
    .r      (raw_score),
    .rank   (rank_index),
    .mode   (mode),
    .worst  (worst_fitness),
    .pop    (population_size),
    .coef   (coef),
    .vld    (out_valid),
    .scaled (scaled_fitness),
    .sat    (saturated)
  );

`ifndef SYNTH
  // a config write always blocks requests on the next cycle
  a_cfg_blocks: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> in_stall)
    else $error("request port open right after config write");

  // pipeline empty after reset
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // outside linear mode, the flag means a clipped value
  a_sat_clip: assert property (@(posedge clk) disable iff (rst)
    (out_valid && saturated && mode != MODE_LINEAR) |->
      (scaled_fitness == 32'sh7fffffff || scaled_fitness == 32'sh80000000))
    else $error("flag set without clipped value");
`endif

endmodule
